// ===== sv/text_line_consistency_distance_unit_macros.svh =====
// ----------------------------------------------------------------------------
// text line consistency distance unit - assertion macros
// immediate-style wrappers around concurrent property checks
// ----------------------------------------------------------------------------
`ifndef TEXT_LINE_CONSISTENCY_DISTANCE_UNIT_MACROS_SVH
`define TEXT_LINE_CONSISTENCY_DISTANCE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TLCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlcd assertion failed");
// next-cycle implication
`define TLCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlcd assertion failed");
`else
`define TLCD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TLCD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/tlcd_pkg.sv =====
// ----------------------------------------------------------------------------
// tlcd_pkg
// widths, types and pair tables shared by the text line distance unit
// ----------------------------------------------------------------------------
`default_nettype none

package tlcd_pkg;

    // coordinate and fixed point widths
    localparam int CB   = 12;
    localparam int FB   = 16;
    localparam int XW   = CB + 1;           // right/bottom corner coordinate
    localparam int SLW  = XW + FB + 1;      // signed slope
    localparam int IW   = XW + SLW + 5;     // signed intercept / residual
    localparam int GW   = IW + 2;           // edge gap
    localparam int MW   = SLW + 1 + XW + 1; // shared multiplier product
    localparam int DW   = GW + 2;           // divider dividend / quotient
    localparam int DVW  = XW + 1;           // divider divisor
    localparam int SPW  = 4;                // split ratio register
    localparam int OW   = 32;               // distance word
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [SPW-1:0] SPLIT_RESET = 4'd6;
    localparam logic [0:0]     REG_SPLIT   = 1'b0;

    typedef struct packed {
        logic [CB-1:0] left;
        logic [CB-1:0] top;
        logic [CB-1:0] width;
        logic [CB-1:0] height;
    } t_box;

    typedef struct packed {
        logic           start;
        logic [DW-1:0]  dividend;
        logic [DVW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic          busy;
        logic          done;
        logic [DW-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic          valid;
        logic [OW-1:0] distance;
        logic          vertical_fault;
    } t_res;

    // corner pairs: (0,1), (0,2), (1,2); third corner is the other one
    function automatic logic [1:0] pair_a(input logic [1:0] k);
        logic [1:0] v;
        case (k)
            2'd2:    v = 2'd1;
            default: v = 2'd0;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] pair_b(input logic [1:0] k);
        logic [1:0] v;
        case (k)
            2'd0:    v = 2'd1;
            default: v = 2'd2;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] pair_c(input logic [1:0] k);
        logic [1:0] v;
        case (k)
            2'd0:    v = 2'd2;
            2'd1:    v = 2'd1;
            default: v = 2'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tlcd_if.sv =====
// ----------------------------------------------------------------------------
// tlcd channel interfaces
// valid/ready channels for box words and distance words
// ----------------------------------------------------------------------------
`default_nettype none

interface tlcd_box_if;
    logic                   valid;
    logic                   ready;
    logic [tlcd_pkg::CB-1:0] box_left;
    logic [tlcd_pkg::CB-1:0] box_top;
    logic [tlcd_pkg::CB-1:0] box_width;
    logic [tlcd_pkg::CB-1:0] box_height;
    logic                   restart;

    modport source (output valid, box_left, box_top, box_width, box_height, restart,
                    input ready);
    modport sink (input valid, box_left, box_top, box_width, box_height, restart,
                  output ready);
endinterface

interface tlcd_res_if;
    logic                    valid;
    logic                    ready;
    logic [tlcd_pkg::OW-1:0] distance;
    logic                    vertical_fault;

    modport source (output valid, distance, vertical_fault, input ready);
    modport sink (input valid, distance, vertical_fault, output ready);
endinterface

`default_nettype wire

// ===== sv/tlcd_div.sv =====
// ----------------------------------------------------------------------------
// tlcd_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tlcd_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tlcd_pkg::t_div_req i_req,
    output tlcd_pkg::t_div_rsp      o_rsp
);

    localparam int CW = $clog2(tlcd_pkg::DW + 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CW-1:0]                 r_cnt;
    logic [tlcd_pkg::DVW-1:0]      r_rem;
    logic [tlcd_pkg::DW-1:0]       r_quo;
    logic [tlcd_pkg::DVW-1:0]      r_den;
    logic [tlcd_pkg::DVW:0]        trial;
    logic                          take;

    // trial subtract of the shifted remainder
    assign trial = {r_rem, r_quo[tlcd_pkg::DW-1]};
    assign take  = trial >= {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(tlcd_pkg::DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[tlcd_pkg::DW-2:0], take};
            r_rem <= take ? tlcd_pkg::DVW'(trial - {1'b0, r_den})
                          : trial[tlcd_pkg::DVW-1:0];
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

// ===== sv/tlcd_core.sv =====
// ----------------------------------------------------------------------------
// tlcd_core
// box history, triplet line fit and distance sequencer around one multiplier
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_line_consistency_distance_unit_macros.svh"

module tlcd_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire tlcd_pkg::t_box                i_box,
    input  wire logic                          i_restart,
    input  wire logic [tlcd_pkg::SPW-1:0]      i_split,
    input  wire logic                          i_out_free,
    output logic                               o_idle,
    output tlcd_pkg::t_res                     o_res
);

    localparam int CB  = tlcd_pkg::CB;
    localparam int FB  = tlcd_pkg::FB;
    localparam int XW  = tlcd_pkg::XW;
    localparam int SLW = tlcd_pkg::SLW;
    localparam int IW  = tlcd_pkg::IW;
    localparam int GW  = tlcd_pkg::GW;
    localparam int MW  = tlcd_pkg::MW;
    localparam int DW  = tlcd_pkg::DW;
    localparam int DVW = tlcd_pkg::DVW;
    localparam int OW  = tlcd_pkg::OW;

    typedef enum logic [18:0] {
        S_IDLE  = 19'h00001,
        S_CHK   = 19'h00002,
        S_CM1   = 19'h00004,
        S_CM2   = 19'h00008,
        S_SDIV  = 19'h00010,
        S_SWAIT = 19'h00020,
        S_B1    = 19'h00040,
        S_BE    = 19'h00080,
        S_BS    = 19'h00100,
        S_T1    = 19'h00200,
        S_TE    = 19'h00400,
        S_TS    = 19'h00800,
        S_FIN   = 19'h01000,
        S_D1    = 19'h02000,
        S_D2    = 19'h04000,
        S_DG    = 19'h08000,
        S_DDIV  = 19'h10000,
        S_DWAIT = 19'h20000,
        S_DONE  = 19'h40000
    } t_state;

    t_state                 r_state;
    tlcd_pkg::t_box         r_box [3];
    logic [1:0]             r_held;
    logic                   r_had;
    logic [1:0]             r_best;
    logic [2:0]             r_k;
    logic signed [MW-1:0]   r_p;
    // current estimate
    logic signed [SLW-1:0]  r_cslope;
    logic signed [IW-1:0]   r_bot1, r_bot2, r_top1, r_top2, r_err;
    logic                   r_cfault;
    // prior estimate
    logic signed [SLW-1:0]  r_pslope;
    logic signed [IW-1:0]   r_pt [2];
    logic signed [IW-1:0]   r_pb [2];
    logic [CB-1:0]          r_pxmin;
    logic [XW-1:0]          r_pxmax;
    logic [CB-1:0]          r_phmax;
    logic                   r_pfault;
    // distance accumulation
    logic signed [GW-1:0]   r_pxa, r_pxb;
    logic [GW-1:0]          r_bt, r_bb;
    logic [OW-1:0]          r_dist;

    tlcd_pkg::t_div_req     div_req;
    tlcd_pkg::t_div_rsp     div_rsp;

    // corner geometry of the held triplet
    logic [XW-1:0]          bx [3];
    logic [XW-1:0]          by [3];
    logic signed [XW:0]     dxs [3];
    logic signed [XW:0]     dys [3];
    logic [XW-1:0]          adx [3];
    logic [XW-1:0]          ady [3];
    logic [CB-1:0]          cxmin;
    logic [XW-1:0]          cxmax;
    logic [CB-1:0]          chmax;
    logic                   eq_fault;
    logic [CB-1:0]          d01, d02, d12;
    logic [1:0]             ti, tj, to;
    logic [CB-1:0]          mx, my;
    logic [1:0]             h0;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            bx[k] = XW'(r_box[k].left) + XW'(r_box[k].width);
            by[k] = XW'(r_box[k].top) + XW'(r_box[k].height);
        end
        for (int k = 0; k < 3; k++) begin
            dxs[k] = $signed({1'b0, bx[tlcd_pkg::pair_b(2'(k))]})
                   - $signed({1'b0, bx[tlcd_pkg::pair_a(2'(k))]});
            dys[k] = $signed({1'b0, by[tlcd_pkg::pair_b(2'(k))]})
                   - $signed({1'b0, by[tlcd_pkg::pair_a(2'(k))]});
            adx[k] = dxs[k][XW] ? XW'(-dxs[k]) : XW'(dxs[k]);
            ady[k] = dys[k][XW] ? XW'(-dys[k]) : XW'(dys[k]);
        end
        cxmin = r_box[0].left;
        cxmax = '0;
        chmax = '0;
        for (int k = 0; k < 3; k++) begin
            if (r_box[k].left < cxmin) cxmin = r_box[k].left;
            if (bx[k] > cxmax) cxmax = bx[k];
            if (r_box[k].height > chmax) chmax = r_box[k].height;
        end
        eq_fault = (bx[0] == bx[1]) || (bx[0] == bx[2]) || (bx[1] == bx[2]);
    end

    // top line pair: the two boxes with the closest top edges
    function automatic logic [CB-1:0] absdiff(input logic [CB-1:0] a, input logic [CB-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    always_comb begin
        d01 = absdiff(r_box[0].top, r_box[1].top);
        d02 = absdiff(r_box[0].top, r_box[2].top);
        d12 = absdiff(r_box[1].top, r_box[2].top);
        if (d01 < d02 && d01 < d12) begin
            ti = 2'd0; tj = 2'd1; to = 2'd2;
        end else if (d02 < d12) begin
            ti = 2'd0; tj = 2'd2; to = 2'd1;
        end else begin
            ti = 2'd1; tj = 2'd2; to = 2'd0;
        end
        mx = CB'((XW'(r_box[ti].left) + XW'(r_box[tj].left)) >> 1);
        my = CB'((XW'(r_box[ti].top) + XW'(r_box[tj].top)) >> 1);
    end

    // pixel value to fixed point
    function automatic logic signed [IW-1:0] fx(input logic [XW-1:0] v);
        return $signed({{(IW-XW-FB){1'b0}}, v, {FB{1'b0}}});
    endfunction

    // residual above h_max / ratio opens a second line; a ratio of 0 never splits
    function automatic logic needs_split(input logic signed [IW-1:0] err,
                                         input logic [CB-1:0] hmax,
                                         input logic [tlcd_pkg::SPW-1:0] ratio);
        logic [IW-1:0]                 m;
        logic [CB+FB-1:0]              lim;
        logic [IW+tlcd_pkg::SPW-1:0]   prod;
        m    = err[IW-1] ? IW'(-err) : IW'(err);
        lim  = {hmax, {FB{1'b0}}};
        prod = (IW+tlcd_pkg::SPW)'(m) * (IW+tlcd_pkg::SPW)'(ratio);
        return (ratio != '0) && ((m > IW'(lim)) || (prod > (IW+tlcd_pkg::SPW)'(lim)));
    endfunction

    // shared multiplier
    logic signed [SLW:0]    m_a;
    logic signed [XW:0]     m_b;
    logic signed [MW-1:0]   m_p;
    logic signed [IW-1:0]   m_px;
    logic signed [SLW:0]    dslope;
    logic [1:0]             pa_b, pc_b;

    assign pa_b   = tlcd_pkg::pair_a(r_best);
    assign pc_b   = tlcd_pkg::pair_c(r_best);
    assign dslope = $signed({r_pslope[SLW-1], r_pslope}) - $signed({r_cslope[SLW-1], r_cslope});

    always_comb begin
        m_a = $signed({r_cslope[SLW-1], r_cslope});
        m_b = $signed({1'b0, bx[pa_b]});
        case (r_state)
            S_CM1: begin
                m_a = $signed((SLW+1)'(ady[r_k[1:0]]));
                m_b = $signed({1'b0, adx[r_best]});
            end
            S_CM2: begin
                m_a = $signed((SLW+1)'(ady[r_best]));
                m_b = $signed({1'b0, adx[r_k[1:0]]});
            end
            S_BE:    m_b = $signed({1'b0, bx[pc_b]});
            S_T1:    m_b = $signed((XW+1)'(mx));
            S_TE:    m_b = $signed((XW+1)'(r_box[to].left));
            S_D1: begin
                m_a = dslope;
                m_b = $signed((XW+1)'((r_pxmin < cxmin) ? r_pxmin : cxmin));
            end
            S_D2: begin
                m_a = dslope;
                m_b = $signed({1'b0, (r_pxmax > cxmax) ? r_pxmax : cxmax});
            end
            default: ;
        endcase
    end

    assign m_p  = m_a * m_b;
    assign m_px = $signed({{(IW-MW){m_p[MW-1]}}, m_p});

    // one edge gap per cycle of the distance loop
    logic signed [IW-1:0]   ga0, gb0;
    logic signed [GW-1:0]   gd, gsa, gsb;
    logic [GW-1:0]          gma, gmb, gap;

    always_comb begin
        if (r_k[2]) begin
            ga0 = r_pb[r_k[1]];
            gb0 = r_k[0] ? r_bot2 : r_bot1;
        end else begin
            ga0 = r_pt[r_k[1]];
            gb0 = r_k[0] ? r_top2 : r_top1;
        end
        gd  = $signed({{(GW-IW){ga0[IW-1]}}, ga0}) - $signed({{(GW-IW){gb0[IW-1]}}, gb0});
        gsa = gd + r_pxa;
        gsb = gd + r_pxb;
        gma = gsa[GW-1] ? GW'(-gsa) : GW'(gsa);
        gmb = gsb[GW-1] ? GW'(-gsb) : GW'(gsb);
        gap = (gma > gmb) ? gma : gmb;
    end

    // divider operands
    logic [CB-1:0]          hsel;
    logic [GW-1:0]          num;
    logic                   sneg;

    always_comb begin
        hsel = (r_phmax > chmax) ? r_phmax : chmax;
        if (hsel == '0) hsel = CB'(1);
        num  = (r_bt > r_bb) ? r_bt : r_bb;
        sneg = dys[r_best][XW] != dxs[r_best][XW];
        div_req.start    = 1'b0;
        div_req.dividend = DW'({num, 1'b0}) + DW'(hsel);
        div_req.divisor  = DVW'({hsel, 1'b0});
        if (r_state == S_SDIV) begin
            div_req.start    = 1'b1;
            div_req.dividend = DW'({ady[r_best], 1'b0, {FB{1'b0}}}) + DW'(adx[r_best]);
            div_req.divisor  = DVW'({adx[r_best], 1'b0});
        end else if (r_state == S_DDIV) begin
            div_req.start = 1'b1;
        end
    end

    tlcd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign h0 = i_restart ? 2'd0 : r_held;

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_held  <= '0;
            r_had   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_had <= (h0 == 2'd3);
                        if (h0 != 2'd3) r_held <= h0 + 2'd1;
                        if (h0 >= 2'd2) r_state <= S_CHK;
                    end
                end
                S_CHK:   r_state <= eq_fault ? S_FIN : S_CM1;
                S_CM1:   r_state <= S_CM2;
                S_CM2:   r_state <= (r_k == 3'd2) ? S_SDIV : S_CM1;
                S_SDIV:  r_state <= S_SWAIT;
                S_SWAIT: if (div_rsp.done) r_state <= S_B1;
                S_B1:    r_state <= S_BE;
                S_BE:    r_state <= S_BS;
                S_BS:    r_state <= S_T1;
                S_T1:    r_state <= S_TE;
                S_TE:    r_state <= S_TS;
                S_TS:    r_state <= S_FIN;
                S_FIN:   r_state <= (r_had && !r_cfault && !r_pfault) ? S_D1 : S_DONE;
                S_D1:    r_state <= S_D2;
                S_D2:    r_state <= S_DG;
                S_DG:    if (r_k == 3'd7) r_state <= S_DDIV;
                S_DDIV:  r_state <= S_DWAIT;
                S_DWAIT: if (div_rsp.done) r_state <= S_DONE;
                S_DONE:  if (i_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (h0 != 2'd3) begin
                        r_box[h0] <= i_box;
                    end else begin
                        r_box[0] <= r_box[1];
                        r_box[1] <= r_box[2];
                        r_box[2] <= i_box;
                    end
                end
            end
            S_CHK: begin
                r_cfault <= eq_fault;
                r_cslope <= '0;
                r_bot1   <= '0;
                r_bot2   <= '0;
                r_top1   <= '0;
                r_top2   <= '0;
                r_best   <= 2'd0;
                r_k      <= 3'd1;
            end
            S_CM1: r_p <= m_p;
            S_CM2: begin
                if (r_p < m_p) r_best <= r_k[1:0];
                r_k <= r_k + 3'd1;
            end
            S_SWAIT: begin
                if (div_rsp.done) begin
                    r_cslope <= sneg ? -$signed(SLW'(div_rsp.quotient))
                                     : $signed(SLW'(div_rsp.quotient));
                end
            end
            S_B1:  r_bot1 <= fx(by[pa_b]) - m_px;
            S_BE:  r_err  <= fx(by[pc_b]) - (r_bot1 + m_px);
            S_BS:  r_bot2 <= needs_split(r_err, chmax, i_split) ? r_bot1 + r_err : r_bot1;
            S_T1:  r_top1 <= fx(XW'(my)) - m_px;
            S_TE:  r_err  <= fx(XW'(r_box[to].top)) - (r_top1 + m_px);
            S_TS:  r_top2 <= needs_split(r_err, chmax, i_split) ? r_top1 + r_err : r_top1;
            S_D1: begin
                r_pxa <= $signed({{(GW-MW){m_p[MW-1]}}, m_p});
                r_bt  <= '1;
                r_bb  <= '1;
                r_k   <= 3'd0;
            end
            S_D2:  r_pxb <= $signed({{(GW-MW){m_p[MW-1]}}, m_p});
            S_DG: begin
                if (r_k[2]) begin
                    if (gap < r_bb) r_bb <= gap;
                end else begin
                    if (gap < r_bt) r_bt <= gap;
                end
                r_k <= r_k + 3'd1;
            end
            S_DWAIT: begin
                if (div_rsp.done) begin
                    r_dist <= (|div_rsp.quotient[DW-1:OW]) ? '1 : div_rsp.quotient[OW-1:0];
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    r_pslope <= r_cslope;
                    r_pt[0]  <= r_top1;
                    r_pt[1]  <= r_top2;
                    r_pb[0]  <= r_bot1;
                    r_pb[1]  <= r_bot2;
                    r_pxmin  <= cxmin;
                    r_pxmax  <= cxmax;
                    r_phmax  <= chmax;
                    r_pfault <= r_cfault;
                end
            end
            default: ;
        endcase
    end

    // result word
    assign o_idle               = r_state == S_IDLE;
    assign o_res.valid          = (r_state == S_DONE) && i_out_free && r_had;
    assign o_res.vertical_fault = r_cfault || r_pfault;
    assign o_res.distance       = (r_cfault || r_pfault) ? '1 : r_dist;

    // checks
    `TLCD_ASSERT_IMP(a_div_done_waited, i_clk, i_rst_n, div_rsp.done,
                     (r_state == S_SWAIT) || (r_state == S_DWAIT))
    `TLCD_ASSERT_NXT(a_restart_first, i_clk, i_rst_n, i_start && i_restart,
                     r_held == 2'd1)
    `TLCD_ASSERT_IMP(a_res_needs_prior, i_clk, i_rst_n, o_res.valid, r_had)

endmodule

`default_nettype wire

// ===== sv/text_line_consistency_distance_unit.sv =====
// ----------------------------------------------------------------------------
// text_line_consistency_distance_unit
// text line consistency distance over sliding triplets of character boxes
// ----------------------------------------------------------------------------
// channel   dir  handshake        word
// i_box     in   valid/ready      box_left, box_top, box_width, box_height, restart
// o_res     out  valid/ready      distance, vertical_fault
// apb       in   psel/penable     split_ratio at byte address 0
//
// a box that completes a triplet with a prior triplet in hand runs two passes of the
// shared divider (slope, distance) and the sequencer steps before the next ready;
// a triplet with no distance to compute runs only the slope pass, or no divider
// pass when its own corners share x; any other box is taken without leaving idle
// i_box.ready is high only while the sequencer is idle
// a finished word waits in the output register; the next box is accepted
// meanwhile and its result holds in the sequencer until the register frees
// synchronous active-low reset; box history cleared, split_ratio back to 6
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_consistency_distance_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    tlcd_box_if.sink                            i_box,
    tlcd_res_if.source                          o_res,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tlcd_pkg::APB_AW-1:0]    paddr,
    input  wire logic [tlcd_pkg::APB_DW-1:0]    pwdata,
    output logic [tlcd_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    logic [tlcd_pkg::SPW-1:0]   r_split;
    logic                       r_ovalid;
    logic [tlcd_pkg::OW-1:0]    r_odist;
    logic                       r_ofault;
    logic                       out_free;
    logic                       core_idle;
    tlcd_pkg::t_box             box;
    tlcd_pkg::t_res             res;

    // register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == tlcd_pkg::REG_SPLIT)
                  ? tlcd_pkg::APB_DW'(r_split) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split <= tlcd_pkg::SPLIT_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == tlcd_pkg::REG_SPLIT)) begin
            r_split <= pwdata[tlcd_pkg::SPW-1:0];
        end
    end

    // input word
    assign box.left   = i_box.box_left;
    assign box.top    = i_box.box_top;
    assign box.width  = i_box.box_width;
    assign box.height = i_box.box_height;
    assign i_box.ready = core_idle;

    tlcd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_box.valid && core_idle),
        .i_box      (box),
        .i_restart  (i_box.restart),
        .i_split    (r_split),
        .i_out_free (out_free),
        .o_idle     (core_idle),
        .o_res      (res)
    );

    // output register
    assign out_free = !r_ovalid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res.valid) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_odist  <= res.distance;
            r_ofault <= res.vertical_fault;
        end
    end

    assign o_res.valid          = r_ovalid;
    assign o_res.distance       = r_odist;
    assign o_res.vertical_fault = r_ofault;

endmodule

`default_nettype wire
